// ----- hw/rtl/b32d_pkg.sv -----
// Shared types and constants for the base32 character decoder.
// No dependencies; every other file of the decoder imports this package.
package b32d_pkg;

    localparam int unsigned DEFAULT_MAX_OUTPUT_BYTES = 65535;
    localparam int unsigned DEFAULT_QUEUE_DEPTH      = 2;

    localparam int unsigned COUNT_W = 16;
    localparam int unsigned ACC_W   = 12;
    localparam int unsigned HELD_W  = 4;
    localparam int unsigned SYM_W   = 5;

    localparam logic [7:0] SYM_MASK     = 8'h1F;
    localparam logic [7:0] DIGIT_OFFSET = 8'd24;
    localparam logic [7:0] CH_O         = 8'h4F;
    localparam logic [7:0] CH_L         = 8'h4C;
    localparam logic [7:0] CH_B         = 8'h42;

    typedef enum logic [1:0] {
        KIND_SYM,
        KIND_SKIP,
        KIND_BAD
    } sym_kind_t;

    typedef struct packed {
        sym_kind_t          kind;
        logic [SYM_W-1:0]   value;
        logic               last;
    } item_t;

endpackage

// ----- hw/rtl/b32d_front.sv -----
// Front end of the decoder: accepts characters and classifies them.
// Depends on b32d_pkg; feeds b32d_queue.
module b32d_front (
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      character,
    input  logic            last_char,
    output logic            push_valid,
    input  logic            push_ready,
    output b32d_pkg::item_t push_item
);
    import b32d_pkg::*;

    logic [7:0] ch_alias;

    always_comb
    begin
        case (character)
            8'h30:   ch_alias = CH_O;
            8'h31:   ch_alias = CH_L;
            8'h38:   ch_alias = CH_B;
            default: ch_alias = character;
        endcase
    end

    always_comb
    begin
        push_item.last = last_char;
        push_item.kind = KIND_BAD;
        push_item.value = '0;
        if (character inside {8'h20, 8'h09, 8'h0D, 8'h0A, 8'h2D})
        begin
            push_item.kind = KIND_SKIP;
        end
        else if (ch_alias inside {[8'h41:8'h5A], [8'h61:8'h7A]})
        begin
            push_item.kind = KIND_SYM;
            push_item.value = SYM_W'((ch_alias & SYM_MASK) - 8'd1);
        end
        else if (ch_alias inside {[8'h32:8'h37]})
        begin
            push_item.kind = KIND_SYM;
            push_item.value = SYM_W'(ch_alias - DIGIT_OFFSET);
        end
    end

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

// ----- hw/rtl/b32d_queue.sv -----
// Short queue of classified characters between the front and back ends.
// Depends on b32d_pkg for the item type.
module b32d_queue #(
    parameter int unsigned DEPTH = b32d_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  b32d_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output b32d_pkg::item_t pop_item
);
    import b32d_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/b32d_back.sv -----
// Back end of the decoder: bit accumulation, byte count and the output register.
// Depends on b32d_pkg; takes classified characters from b32d_queue.
module b32d_back #(
    parameter int unsigned MAX_OUTPUT_BYTES = b32d_pkg::DEFAULT_MAX_OUTPUT_BYTES
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  b32d_pkg::item_t item,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            bad_char,
    output logic            string_end,
    output logic [15:0]     bytes_decoded
);
    import b32d_pkg::*;

    localparam int unsigned LIMIT_INT = (MAX_OUTPUT_BYTES > 65535) ? 65535 : MAX_OUTPUT_BYTES;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(LIMIT_INT);

    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [HELD_W-1:0]  held_reg, held_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               err_reg, err_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg;
    logic               byte_valid_reg;
    logic               bad_char_reg;
    logic               string_end_reg;
    logic [COUNT_W-1:0] bytes_reg;

    logic               take;
    logic               emit;
    logic               have_byte;
    logic [7:0]         new_byte;
    logic [ACC_W-1:0]   acc_shift;
    logic [HELD_W-1:0]  held_sum;
    logic [HELD_W-1:0]  held_rem;
    logic [COUNT_W-1:0] count_upd;
    logic               err_upd;

    assign item_ready = !out_valid_reg || out_ready;
    assign take       = item_valid && item_ready;

    assign acc_shift = {acc_reg[ACC_W-SYM_W-1:0], item.value};
    assign held_sum  = held_reg + HELD_W'(SYM_W);
    assign held_rem  = held_sum - HELD_W'(8);

    always_comb
    begin
        acc_next  = acc_reg;
        held_next = held_reg;
        count_upd = count_reg;
        err_upd   = err_reg;
        emit      = 1'b0;
        have_byte = 1'b0;
        new_byte  = '0;
        if (!err_reg)
        begin
            case (item.kind)
                KIND_BAD:
                begin
                    err_upd = 1'b1;
                    emit    = 1'b1;
                end
                KIND_SYM:
                begin
                    if (held_sum >= HELD_W'(8))
                    begin
                        held_next = held_rem;
                        new_byte  = 8'(acc_shift >> held_rem);
                        acc_next  = acc_shift & ~({ACC_W{1'b1}} << held_rem);
                        have_byte = 1'b1;
                        emit      = 1'b1;
                        if (count_reg < COUNT_LIMIT)
                        begin
                            count_upd = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        held_next = held_sum;
                        acc_next  = acc_shift;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (item.last)
        begin
            emit = 1'b1;
        end
        count_next = count_upd;
        err_next   = err_upd;
        if (item.last)
        begin
            acc_next   = '0;
            held_next  = '0;
            count_next = '0;
            err_next   = 1'b0;
        end
    end

    always_comb
    begin
        if (take)
        begin
            out_valid_next = emit;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            held_reg      <= '0;
            count_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                acc_reg   <= acc_next;
                held_reg  <= held_next;
                count_reg <= count_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_byte_reg   <= new_byte;
            byte_valid_reg <= have_byte;
            bad_char_reg   <= err_upd;
            string_end_reg <= item.last;
            bytes_reg      <= count_upd;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign byte_valid    = byte_valid_reg;
    assign bad_char      = bad_char_reg;
    assign string_end    = string_end_reg;
    assign bytes_decoded = bytes_reg;

    // Between characters fewer than eight bits are pending, and nothing lies above them.
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HELD_W'(7))
        else $error("pending bit count out of range");

    a_acc_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg >> held_reg) == '0)
        else $error("stale bits above the pending bits");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.last |=> held_reg == '0 && count_reg == '0 && !err_reg)
        else $error("string state not cleared after the last character");

    a_byte_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(byte_valid_reg && bad_char_reg))
        else $error("decoded byte reported together with a bad character");

    a_byte_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && byte_valid_reg |-> bytes_reg != '0)
        else $error("decoded byte without a byte count");

endmodule

// ----- hw/rtl/base32_char_decoder_top.sv -----
// Base32 character decoder: one character per transfer in, at most one result out.
// A character is registered in the queue, then its result in the output register.
// Throughput is one character per cycle while the output is not stalled by out_ready.
// Reset clears the bit accumulator, byte count, error flag, queue and output valid.
// Depends on b32d_pkg, b32d_front, b32d_queue and b32d_back.
module base32_char_decoder_top #(
    parameter int unsigned MAX_OUTPUT_BYTES = b32d_pkg::DEFAULT_MAX_OUTPUT_BYTES,
    parameter int unsigned QUEUE_DEPTH      = b32d_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  character,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        bad_char,
    output logic        string_end,
    output logic [15:0] bytes_decoded
);
    import b32d_pkg::*;

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    b32d_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .character  (character),
        .last_char  (last_char),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    b32d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    b32d_back #(
        .MAX_OUTPUT_BYTES (MAX_OUTPUT_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (pop_valid),
        .item_ready    (pop_ready),
        .item          (pop_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .bad_char      (bad_char),
        .string_end    (string_end),
        .bytes_decoded (bytes_decoded)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for base32_char_decoder_top: directed and random character streams,
// checked result by result against a behavioural decoder in this file or typed rows of the plan.
// Depends on b32d_pkg and the RTL of the decoder; it needs no other file.
`timescale 1ns / 100ps

module testbench;

    import b32d_pkg::*;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [15:0] COUNT_CAP =
        (DEFAULT_MAX_OUTPUT_BYTES > 65535) ? 16'hFFFF : 16'(DEFAULT_MAX_OUTPUT_BYTES);
    localparam int RANDOM_CHARS = 1200;

    typedef struct packed {
        logic [7:0]  data;
        logic        has_data;
        logic        bad;
        logic        closes;
        logic [15:0] count;
    } decode_result_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        fin;
        logic        typed;
        logic        has;
        logic [7:0]  data;
        logic        has_data;
        logic        bad;
        logic        closes;
        logic [15:0] count;
    } stim_row_t;

    localparam stim_row_t PLAN [0:24] = '{
        '{8'h00,  1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0, 16'd0},
        '{"A",    1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 16'd0},
        '{" ",    1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 16'd0},
        '{"A",    1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{"a",    1'b0, 1'b1, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 16'd1},
        '{CH_TAB, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{CH_CR,  1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{CH_LF,  1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{"-",    1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{"7",    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{"z",    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{"Z",    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{"2",    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{"0",    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{"1",    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{"8",    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{"b",    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{"=",    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{"Q",    1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{8'hFF,  1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{8'hFF,  1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0, 16'd0},
        '{"A",    1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 16'd0},
        '{"7",    1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{"7",    1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{8'h80,  1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 16'd0}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  character;
    logic        last_char;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        bad_char;
    logic        string_end;
    logic [15:0] bytes_decoded;

    logic [11:0] pend_bits;
    logic [3:0]  pend_n;
    logic [15:0] str_count;
    logic        str_bad;

    decode_result_t pending_results[$];
    decode_result_t row_exp;
    bit             row_typed;
    bit             row_has;
    bit             calm;
    int             counted_chars;
    int             errors;

    base32_char_decoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .character     (character),
        .last_char     (last_char),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .bad_char      (bad_char),
        .string_end    (string_end),
        .bytes_decoded (bytes_decoded)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic sym_kind_t classify_char(input logic [7:0] ch, output logic [4:0] val);
        logic [7:0] c;
        logic [7:0] t;
        c = ch;
        val = '0;
        if (c == " " || c == CH_TAB || c == CH_CR || c == CH_LF || c == "-")
            return KIND_SKIP;
        if (c == "0")
            c = CH_O;
        else if (c == "1")
            c = CH_L;
        else if (c == "8")
            c = CH_B;
        if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
        begin
            t = (c & SYM_MASK) - 8'd1;
            val = t[4:0];
            return KIND_SYM;
        end
        if (c >= "2" && c <= "7")
        begin
            t = c - DIGIT_OFFSET;
            val = t[4:0];
            return KIND_SYM;
        end
        return KIND_BAD;
    endfunction

    // Advances the decoder state by one character and reports whether a result is due.
    function automatic bit decode_char_step(input logic [7:0] ch, input logic fin,
                                            output decode_result_t r);
        logic [4:0] val;
        int         n;
        bit         emit;
        r = '0;
        emit = 1'b0;
        if (!str_bad)
        begin
            case (classify_char(ch, val))
                KIND_BAD:
                begin
                    str_bad = 1'b1;
                    emit = 1'b1;
                end
                KIND_SYM:
                begin
                    pend_bits = {pend_bits[6:0], val};
                    n = pend_n + 5;
                    if (n >= 8)
                    begin
                        n = n - 8;
                        r.data = 8'(pend_bits >> n);
                        r.has_data = 1'b1;
                        pend_bits = pend_bits & ((12'd1 << n) - 12'd1);
                        emit = 1'b1;
                        if (str_count < COUNT_CAP)
                            str_count = str_count + 16'd1;
                    end
                    pend_n = 4'(n);
                end
                default: ;
            endcase
        end
        if (fin)
            emit = 1'b1;
        r.bad = str_bad;
        r.closes = fin;
        r.count = str_count;
        if (fin)
        begin
            pend_bits = '0;
            pend_n = '0;
            str_count = '0;
            str_bad = 1'b0;
        end
        return emit;
    endfunction

    function automatic logic [7:0] symbol_char(input logic [4:0] v);
        logic [7:0] c;
        if (v >= 5'd26)
            return {3'b000, v} + DIGIT_OFFSET;
        c = {3'b000, v} + "A";
        if ($urandom_range(1, 0) == 1)
            c = c | 8'h20;
        if ($urandom_range(1, 0) == 1)
        begin
            if (v == 5'd14)
                c = "0";
            else if (v == 5'd11)
                c = "1";
            else if (v == 5'd1)
                c = "8";
        end
        return c;
    endfunction

    function automatic logic [7:0] skip_char();
        case ($urandom_range(4, 0))
            0: return " ";
            1: return CH_TAB;
            2: return CH_CR;
            3: return CH_LF;
            default: return "-";
        endcase
    endfunction

    function automatic logic [7:0] invalid_char();
        logic [7:0] c;
        logic [4:0] v;
        c = 8'($urandom_range(255, 0));
        while (classify_char(c, v) != KIND_BAD)
            c = 8'($urandom_range(255, 0));
        return c;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    task automatic send_char(input logic [7:0] ch, input logic fin);
        int gap;
        gap = calm ? 0 : $urandom_range(18, 0);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        character <= ch;
        last_char <= fin;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Both transfers are observed mid-cycle, where every signal has settled since the edge.
    always @(negedge clk)
    begin : watch
        decode_result_t r;
        decode_result_t e;
        logic [4:0]     v;
        bit             due;
        if (rst_n && in_valid && in_ready)
        begin
            if (last_char || (!str_bad && classify_char(character, v) != KIND_SKIP))
                counted_chars++;
            due = decode_char_step(character, last_char, r);
            if (row_typed)
            begin
                due = row_has;
                r = row_exp;
            end
            if (due)
                pending_results.push_back(r);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with none pending: out_byte %0h byte_valid %0b count %0d",
                       out_byte, byte_valid, bytes_decoded);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("out_byte", 16'(e.data), 16'(out_byte));
                check_field("byte_valid", 16'(e.has_data), 16'(byte_valid));
                check_field("bad_char", 16'(e.bad), 16'(bad_char));
                check_field("string_end", 16'(e.closes), 16'(string_end));
                check_field("bytes_decoded", e.count, bytes_decoded);
            end
        end
    end

    initial
    begin : sink
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(18, 0);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(negedge clk);
            while (!out_valid)
                @(negedge clk);
            @(posedge clk);
        end
    end

    initial
    begin : source
        logic [7:0] txt[$];
        int         base;
        int         n;
        int         style;
        bit         drained;
        pend_bits = '0;
        pend_n = '0;
        str_count = '0;
        str_bad = 1'b0;
        row_typed = 1'b0;
        row_has = 1'b0;
        row_exp = '0;
        calm = 1'b0;
        counted_chars = 0;
        errors = 0;
        drained = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        character <= '0;
        last_char <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[i])
        begin
            row_typed = PLAN[i].typed;
            row_has = PLAN[i].has;
            row_exp = '{PLAN[i].data, PLAN[i].has_data, PLAN[i].bad, PLAN[i].closes,
                        PLAN[i].count};
            send_char(PLAN[i].ch, PLAN[i].fin);
            row_typed = 1'b0;
        end

        base = counted_chars;
        while (counted_chars - base < RANDOM_CHARS)
        begin
            calm = ($urandom_range(9, 0) < 3);
            style = $urandom_range(9, 0);
            txt.delete();
            if (style == 0)
            begin
                n = $urandom_range(20, 1);
                repeat (n) txt.push_back(8'($urandom_range(255, 0)));
            end
            else
            begin
                n = $urandom_range(40, 0);
                repeat (n)
                begin
                    if ($urandom_range(9, 0) == 0)
                        txt.push_back(skip_char());
                    txt.push_back(symbol_char(5'($urandom_range(31, 0))));
                end
                if (style <= 2)
                    txt.insert($urandom_range(txt.size(), 0), invalid_char());
                if (txt.size() == 0 || $urandom_range(7, 0) == 0)
                    txt.push_back(skip_char());
            end
            foreach (txt[k])
                send_char(txt[k], k == txt.size() - 1);
            if (!drained && counted_chars - base >= RANDOM_CHARS / 2)
            begin
                drained = 1'b1;
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- base32_char_decoder_top.f -----
hw/rtl/b32d_pkg.sv
hw/rtl/b32d_front.sv
hw/rtl/b32d_queue.sv
hw/rtl/b32d_back.sv
hw/rtl/base32_char_decoder_top.sv
tb/testbench.sv
